[design/rtce_pkg.sv]
// Package for the Toffoli cascade evaluator: word types, code constants and defaults.
// Has no dependencies; the cascade evaluator top level imports it, rtce_ram does not.
`timescale 1ns / 1ps

package rtce_pkg;

	localparam int QUBITS_DEF = 16;
	localparam int GATES_DEF  = 64;

	localparam int CODES_W  = 32;
	localparam int STATE_W  = 16;
	localparam int SLOT_W   = 6;
	localparam int COUNT_W  = 7;

	localparam logic [1:0] CODE_NEG  = 2'd0;
	localparam logic [1:0] CODE_POS  = 2'd1;
	localparam logic [1:0] CODE_TGT  = 2'd2;
	localparam logic [1:0] CODE_WIRE = 2'd3;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [SLOT_W-1:0]  gate_slot;
		logic [CODES_W-1:0] gate_codes;
		logic [STATE_W-1:0] state_in;
	} item_t;

	typedef struct packed {
		logic               result_kind;
		logic [STATE_W-1:0] state_out;
		logic               no_target_error;
	} result_t;

endpackage

[design/reversible_toffoli_cascade_eval.sv]
// A load word returns its acknowledge in the cycle after acceptance; an evaluate word returns
// its result once n gates have been applied, n being gates_in_use capped at GATES.
// One load per cycle while not busy; evaluations keep busy high and apply one gate per cycle,
// set by the single read port of the gate memory. The receiver cannot stall results.
// Reset clears the control state and gates_in_use; gate memory contents are undefined.
// Depends on rtce_pkg and rtce_ram.
`timescale 1ns / 1ps

module reversible_toffoli_cascade_eval
	import rtce_pkg::*;
#(
	parameter int QUBITS = QUBITS_DEF,
	parameter int GATES  = GATES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  item_t              item,
	output logic               done,
	output result_t            result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data
);

	localparam int AW    = (GATES > 1) ? $clog2(GATES) : 1;
	localparam int CW    = $clog2(GATES + 1);
	localparam int EXT_W = (2 * QUBITS > CODES_W) ? 2 * QUBITS : CODES_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	function automatic logic [QUBITS-1:0] apply_gate(input logic [CODES_W-1:0] codes,
			input logic [QUBITS-1:0] st);
		logic [EXT_W-1:0]  ext;
		logic [QUBITS-1:0] flip;
		logic              match;
		logic [1:0]        c;
		logic              b;
		ext   = EXT_W'(codes);
		flip  = '0;
		match = 1'b1;
		for (int k = 0; k < QUBITS; k++) begin
			c = ext[2*k +: 2];
			b = st[QUBITS-1-k];
			if (c == CODE_NEG && b) begin
				match = 1'b0;
			end
			if (c == CODE_POS && !b) begin
				match = 1'b0;
			end
			if (c == CODE_TGT) begin
				flip[QUBITS-1-k] = 1'b1;
			end
		end
		return match ? (st ^ flip) : st;
	endfunction

	function automatic logic has_target(input logic [CODES_W-1:0] codes);
		logic [EXT_W-1:0] ext;
		logic             hit;
		ext = EXT_W'(codes);
		hit = 1'b0;
		for (int k = 0; k < QUBITS; k++) begin
			if (ext[2*k +: 2] == CODE_TGT) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	logic               state_q;
	logic               done_q;
	logic [COUNT_W-1:0] gates_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      n_q;
	logic [QUBITS-1:0]  st_q;
	result_t            res_q;

	logic               accept;
	logic               is_load;
	logic [CW-1:0]      n_sat;
	logic [QUBITS-1:0]  st_in;
	logic [QUBITS-1:0]  st_next;
	logic               last;
	logic               mem_we;
	logic [AW-1:0]      mem_raddr;
	logic [CODES_W-1:0] mem_rdata;

	assign accept    = start && !busy;
	assign is_load   = (item.mode == MODE_LOAD);
	assign busy      = (state_q == ST_RUN);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	assign n_sat   = (32'(gates_q) > 32'(GATES)) ? CW'(GATES) : CW'(gates_q);
	assign st_in   = QUBITS'(item.state_in);
	assign st_next = apply_gate(mem_rdata, st_q);
	assign last    = (idx_q == n_q);

	assign mem_we    = accept && is_load && (32'(item.gate_slot) < 32'(GATES));
	assign mem_raddr = (state_q == ST_RUN) ? idx_q[AW-1:0] : '0;

	rtce_ram #(
		.WIDTH(CODES_W),
		.DEPTH(GATES)
	) u_gate_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(AW'(item.gate_slot)),
		.wdata(item.gate_codes),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			gates_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				gates_q <= cfg_data;
			end
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_load || n_sat == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (last) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= CW'(1);
			n_q   <= n_sat;
			st_q  <= st_in;
			if (is_load) begin
				res_q <= '{result_kind: KIND_ACK, state_out: '0,
					no_target_error: !has_target(item.gate_codes)};
			end else begin
				res_q <= '{result_kind: KIND_EVAL, state_out: STATE_W'(st_in),
					no_target_error: 1'b0};
			end
		end else if (state_q == ST_RUN) begin
			idx_q <= idx_q + CW'(1);
			st_q  <= st_next;
			if (last) begin
				res_q <= '{result_kind: KIND_EVAL, state_out: STATE_W'(st_next),
					no_target_error: 1'b0};
			end
		end
	end

endmodule

[design/rtce_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Uses no package content; instantiated by the cascade evaluator top level.
`timescale 1ns / 1ps

module rtce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
